// ----- rtl/core/max_2x2_window_sum_locator_defines.svh -----
// ----------------------------------------------------------------------------
// max_2x2_window_sum_locator assertion macros
// shared assertion forms for the window sum locator checkers
// ----------------------------------------------------------------------------
`ifndef MAX_2X2_WINDOW_SUM_LOCATOR_DEFINES_SVH
`define MAX_2X2_WINDOW_SUM_LOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MWS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mws check failed");

// next-cycle implication, sampled on clk, off during reset
`define MWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mws check failed");

`endif

// ----- rtl/core/mws_pkg.sv -----
// ----------------------------------------------------------------------------
// mws_pkg
// types and constants of the 2x2 window sum locator
// ----------------------------------------------------------------------------
package mws_pkg;

    localparam int ELEM_W       = 32;
    localparam int SUM_W        = 33;
    localparam int IDX_W        = 10;
    localparam int CFG_W        = 11;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    localparam int OUT_FIELDS_W = SUM_W + 2 * IDX_W + 4 * ELEM_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

    typedef enum logic [0:0] {
        REG_NUM_ROWS = 1'b0,
        REG_NUM_COLS = 1'b1
    } cfg_reg_e;

    typedef struct packed {
        logic valid;
        logic window;
        logic last;
    } stage_t;

endpackage

// ----- rtl/core/max_2x2_window_sum_locator.sv -----
// ----------------------------------------------------------------------------
// max_2x2_window_sum_locator
// locates the 2x2 window with the largest sum in a raster matrix
// ----------------------------------------------------------------------------
// usage:
//   set num_rows (addr 0) and num_cols (addr 4) over apb while idle
//   feed the matrix row by row, one signed element per s_axis beat
//   after the last element one result beat leaves on m_axis:
//     tdata holds sum, row, column and the four window elements,
//     tuser flags that some window sum exceeded zero
//   result: the last element passes the stage register, then the result register
//   throughput: one element per cycle, set by the single line buffer port
//     that reads the element above and writes the new one in the same cycle
//   reset: sizes return to 2x2, position and best window are cleared,
//     line buffer contents are not cleared and need none
//   stall: while m_axis is stalled, elements of the next matrix keep
//     flowing; only the next matrix's last element waits for the slot
// ----------------------------------------------------------------------------
module max_2x2_window_sum_locator #(
    parameter int MAX_COLS = mws_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = mws_pkg::DEF_MAX_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mws_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mws_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mws_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mws_pkg::ELEM_W-1:0]        s_axis_tdata,   // element
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // best_sum, best_row, best_col, top_left, top_right, bottom_left, bottom_right
    output logic [mws_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [0:0]                        m_axis_tuser    // found
);
    import mws_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    logic [CFG_W-1:0]  num_rows;
    logic [CFG_W-1:0]  num_cols;
    logic              advance;
    stage_t            stage;
    logic [ELEM_W-1:0] element;
    logic [ELEM_W-1:0] above;
    logic [ROW_W-1:0]  win_row;
    logic [COL_W-1:0]  win_col;

    mws_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .num_rows (num_rows),
        .num_cols (num_cols)
    );

    mws_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .num_rows      (num_rows),
        .num_cols      (num_cols),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .stage         (stage),
        .element       (element),
        .above         (above),
        .win_row       (win_row),
        .win_col       (win_col)
    );

    mws_track #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage         (stage),
        .element       (element),
        .above         (above),
        .win_row       (win_row),
        .win_col       (win_col),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- rtl/core/mws_cfg.sv -----
// ----------------------------------------------------------------------------
// mws_cfg
// apb register file holding the matrix size
// ----------------------------------------------------------------------------
module mws_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mws_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mws_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mws_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [mws_pkg::CFG_W-1:0]        num_rows,
    output logic [mws_pkg::CFG_W-1:0]        num_cols
);
    import mws_pkg::*;

    logic [CFG_W-1:0] num_rows_reg;
    logic [CFG_W-1:0] num_rows_next;
    logic [CFG_W-1:0] num_cols_reg;
    logic [CFG_W-1:0] num_cols_next;
    logic             wr_en;
    cfg_reg_e         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = cfg_reg_e'(paddr[2]);

    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_NUM_ROWS: num_rows_next = pwdata[CFG_W-1:0];
                REG_NUM_COLS: num_cols_next = pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_NUM_ROWS: prdata = APB_DATA_W'(num_rows_reg);
            REG_NUM_COLS: prdata = APB_DATA_W'(num_cols_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= CFG_RESET;
            num_cols_reg <= CFG_RESET;
        end
        else
        begin
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
        end
    end

    assign num_rows = num_rows_reg;
    assign num_cols = num_cols_reg;

endmodule

// ----- rtl/core/mws_front.sv -----
// ----------------------------------------------------------------------------
// mws_front
// raster position counters, line buffer and input stage register
// ----------------------------------------------------------------------------
module mws_front #(
    parameter int MAX_COLS = mws_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = mws_pkg::DEF_MAX_ROWS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mws_pkg::CFG_W-1:0]     num_rows,
    input  logic [mws_pkg::CFG_W-1:0]     num_cols,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mws_pkg::ELEM_W-1:0]    s_axis_tdata,
    input  logic                          advance,
    output mws_pkg::stage_t               stage,
    output logic [mws_pkg::ELEM_W-1:0]    element,
    output logic [mws_pkg::ELEM_W-1:0]    above,
    output logic [$clog2(MAX_ROWS)-1:0]   win_row,
    output logic [$clog2(MAX_COLS)-1:0]   win_col
);
    import mws_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int CC_W  = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int CR_W  = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

    logic [ELEM_W-1:0] line_mem [MAX_COLS];

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              valid_reg;
    logic              valid_next;
    logic              window_reg;
    logic              last_reg;
    logic [ELEM_W-1:0] elem_reg;
    logic [ELEM_W-1:0] above_reg;
    logic [ROW_W-1:0]  win_row_reg;
    logic [COL_W-1:0]  win_col_reg;

    logic [CC_W-1:0]   cols_last;
    logic [CR_W-1:0]   rows_last;
    logic              row_end;
    logic              matrix_end;
    logic              accept;

    // size registers clamped to the supported range
    always_comb
    begin
        priority if (CC_W'(num_cols) < CC_W'(2))
            cols_last = CC_W'(1);
        else if (CC_W'(num_cols) > CC_W'(MAX_COLS))
            cols_last = CC_W'(MAX_COLS - 1);
        else
            cols_last = CC_W'(num_cols) - CC_W'(1);
    end

    always_comb
    begin
        priority if (CR_W'(num_rows) < CR_W'(2))
            rows_last = CR_W'(1);
        else if (CR_W'(num_rows) > CR_W'(MAX_ROWS))
            rows_last = CR_W'(MAX_ROWS - 1);
        else
            rows_last = CR_W'(num_rows) - CR_W'(1);
    end

    assign row_end       = CC_W'(col_reg) >= cols_last;
    assign matrix_end    = row_end && (CR_W'(row_reg) >= rows_last);
    assign s_axis_tready = !valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            priority if (matrix_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
    end

    // read-first line buffer: the previous row's element leaves as the new one lands
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            above_reg        <= line_mem[col_reg];
            line_mem[col_reg] <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            elem_reg    <= s_axis_tdata;
            window_reg  <= (row_reg != '0) && (col_reg != '0);
            last_reg    <= matrix_end;
            win_row_reg <= row_reg - ROW_W'(1);
            win_col_reg <= col_reg - COL_W'(1);
        end
    end

    assign stage.valid  = valid_reg;
    assign stage.window = window_reg;
    assign stage.last   = last_reg;
    assign element      = elem_reg;
    assign above        = above_reg;
    assign win_row      = win_row_reg;
    assign win_col      = win_col_reg;

endmodule

// ----- rtl/core/mws_track.sv -----
// ----------------------------------------------------------------------------
// mws_track
// window sum, best window tracking and result register
// ----------------------------------------------------------------------------
module mws_track #(
    parameter int MAX_COLS = mws_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = mws_pkg::DEF_MAX_ROWS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mws_pkg::stage_t                     stage,
    input  logic [mws_pkg::ELEM_W-1:0]          element,
    input  logic [mws_pkg::ELEM_W-1:0]          above,
    input  logic [$clog2(MAX_ROWS)-1:0]         win_row,
    input  logic [$clog2(MAX_COLS)-1:0]         win_col,
    output logic                                advance,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mws_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic [0:0]                          m_axis_tuser
);
    import mws_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    logic [ELEM_W-1:0]      left_reg;
    logic [ELEM_W-1:0]      ul_reg;
    logic [SUM_W-1:0]       best_sum_reg;
    logic [SUM_W-1:0]       best_sum_next;
    logic [ROW_W-1:0]       best_row_reg;
    logic [ROW_W-1:0]       best_row_next;
    logic [COL_W-1:0]       best_col_reg;
    logic [COL_W-1:0]       best_col_next;
    logic                   found_reg;
    logic                   found_next;
    logic [ELEM_W-1:0]      bw_reg [4];
    logic [ELEM_W-1:0]      bw_next [4];
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [0:0]             out_user_reg;

    logic signed [SUM_W:0]  sum;
    logic                   better;
    logic                   finish;

    assign advance = stage.valid && (!stage.last || !out_valid_reg);
    assign finish  = advance && stage.last;

    assign sum = $signed({{2{ul_reg[ELEM_W-1]}}, ul_reg})
               + $signed({{2{above[ELEM_W-1]}}, above})
               + $signed({{2{left_reg[ELEM_W-1]}}, left_reg})
               + $signed({{2{element[ELEM_W-1]}}, element});

    assign better = stage.window && (sum > $signed({1'b0, best_sum_reg}));

    always_comb
    begin
        best_sum_next = best_sum_reg;
        best_row_next = best_row_reg;
        best_col_next = best_col_reg;
        found_next    = found_reg;
        bw_next       = bw_reg;
        if (better)
        begin
            best_sum_next = sum[SUM_W-1:0];
            best_row_next = win_row;
            best_col_next = win_col;
            found_next    = 1'b1;
            bw_next[0]    = ul_reg;
            bw_next[1]    = above;
            bw_next[2]    = left_reg;
            bw_next[3]    = element;
        end
    end

    assign out_valid_next = finish || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            ul_reg        <= '0;
            best_sum_reg  <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
            found_reg     <= 1'b0;
            bw_reg        <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                left_reg     <= '0;
                ul_reg       <= '0;
                best_sum_reg <= '0;
                best_row_reg <= '0;
                best_col_reg <= '0;
                found_reg    <= 1'b0;
                bw_reg       <= '{default: '0};
            end
            else if (advance)
            begin
                left_reg     <= element;
                ul_reg       <= above;
                best_sum_reg <= best_sum_next;
                best_row_reg <= best_row_next;
                best_col_reg <= best_col_next;
                found_reg    <= found_next;
                bw_reg       <= bw_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, bw_next[3], bw_next[2], bw_next[1],
                             bw_next[0], IDX_W'(best_col_next), IDX_W'(best_row_next),
                             best_sum_next};
            out_user_reg <= found_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ----- rtl/core/mws_checker.sv -----
// ----------------------------------------------------------------------------
// mws_checker
// port-level checks of the window sum locator result stream
// ----------------------------------------------------------------------------
`include "max_2x2_window_sum_locator_defines.svh"

module mws_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [mws_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic [0:0]                        m_axis_tuser
);
    import mws_pkg::*;

    logic signed [SUM_W:0] chk_sum;
    logic [SUM_W-1:0]      out_sum;
    logic                  sum_ok;
    logic [ELEM_W-1:0]     tl;
    logic [ELEM_W-1:0]     tr;
    logic [ELEM_W-1:0]     bl;
    logic [ELEM_W-1:0]     br;

    assign out_sum = m_axis_tdata[SUM_W-1:0];
    assign tl = m_axis_tdata[84:53];
    assign tr = m_axis_tdata[116:85];
    assign bl = m_axis_tdata[148:117];
    assign br = m_axis_tdata[180:149];

    assign chk_sum = $signed({{2{tl[ELEM_W-1]}}, tl}) + $signed({{2{tr[ELEM_W-1]}}, tr})
                   + $signed({{2{bl[ELEM_W-1]}}, bl}) + $signed({{2{br[ELEM_W-1]}}, br});

    assign sum_ok = (chk_sum == $signed({1'b0, out_sum})) && (out_sum != '0);

    `MWS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `MWS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `MWS_ASSERT_SAME(a_none_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)
    `MWS_ASSERT_SAME(a_sum_match, m_axis_tvalid && m_axis_tuser[0], sum_ok)

endmodule

bind max_2x2_window_sum_locator mws_checker u_mws_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/max_2x2_window_sum_locator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_2x2_window_sum_locator_test
// self-checking bench for the 2x2 window sum locator: matrices of signed
// elements stream in under random bursts, gaps and output stalls, a model of
// the window search predicts the one result beat of each matrix, and every
// result beat is compared field by field; sizes are set over apb between
// matrices, covering clamped sizes
// ----------------------------------------------------------------------------
module max_2x2_window_sum_locator_test;

    import mws_pkg::*;

    localparam int ACCEPT_TIMEOUT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 1350;

    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [ELEM_W-1:0]    bottom_right;
        logic [ELEM_W-1:0]    bottom_left;
        logic [ELEM_W-1:0]    top_right;
        logic [ELEM_W-1:0]    top_left;
        logic [IDX_W-1:0]     best_col;
        logic [IDX_W-1:0]     best_row;
        logic [SUM_W-1:0]     best_sum;
    } result_beat_t;

    typedef struct packed {
        logic         found;
        result_beat_t beat;
    } window_result_t;

    typedef enum int {
        DATA_FULL,
        DATA_SMALL,
        DATA_EXTREME,
        DATA_NEGATIVE
    } data_kind_e;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [ELEM_W-1:0]      s_axis_tdata = '0;     // element
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // best_sum, best_row, best_col, top_left, top_right, bottom_left, bottom_right
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;          // found

    // window search model state
    logic [CFG_W-1:0]  size_rows = CFG_RESET;
    logic [CFG_W-1:0]  size_cols = CFG_RESET;
    logic [ELEM_W-1:0] line_buf [DEF_MAX_COLS];
    logic [ELEM_W-1:0] left_elem = '0;
    logic [ELEM_W-1:0] upper_left_elem = '0;
    int unsigned       row_pos = 0;
    int unsigned       col_pos = 0;
    longint            best_total = 0;
    logic [IDX_W-1:0]  best_r = '0;
    logic [IDX_W-1:0]  best_c = '0;
    logic              kept_found = 1'b0;
    logic [ELEM_W-1:0] kept_tl = '0;
    logic [ELEM_W-1:0] kept_tr = '0;
    logic [ELEM_W-1:0] kept_bl = '0;
    logic [ELEM_W-1:0] kept_br = '0;

    window_result_t best_window_queue [$];
    window_result_t want_window;
    result_beat_t   seen_beat;

    int          failures = 0;
    int unsigned items_sent = 0;
    int          burst_left = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          ready_phase = 0;
    int          ready_mode = 0;
    int          idle_cycles = 0;

    max_2x2_window_sum_locator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    function automatic int unsigned fit_size(input logic [CFG_W-1:0] value,
                                             input int unsigned limit);
        if (value < 2)
            return 2;
        if (value > limit)
            return limit;
        return value;
    endfunction

    function automatic void advance_window_search(input logic [ELEM_W-1:0] elem);
        int unsigned       rows;
        int unsigned       cols;
        int unsigned       c;
        logic [ELEM_W-1:0] above;
        longint            total;
        window_result_t    res;
        rows = fit_size(size_rows, DEF_MAX_ROWS);
        cols = fit_size(size_cols, DEF_MAX_COLS);
        c = (col_pos >= DEF_MAX_COLS) ? DEF_MAX_COLS - 1 : col_pos;
        above = line_buf[c];
        if (row_pos >= 1 && c >= 1)
        begin
            total = longint'($signed(upper_left_elem)) + longint'($signed(above))
                  + longint'($signed(left_elem)) + longint'($signed(elem));
            // strictly greater: a tie keeps the earlier window
            if (total > best_total)
            begin
                best_total = total;
                best_r = IDX_W'(row_pos - 1);
                best_c = IDX_W'(c - 1);
                kept_found = 1'b1;
                kept_tl = upper_left_elem;
                kept_tr = above;
                kept_bl = left_elem;
                kept_br = elem;
            end
        end
        upper_left_elem = above;
        left_elem = elem;
        line_buf[c] = elem;
        if (c < cols - 1)
            col_pos = c + 1;
        else if (row_pos < rows - 1)
        begin
            col_pos = 0;
            row_pos++;
        end
        else
        begin
            res = '0;
            res.found = kept_found;
            res.beat.best_sum = best_total[SUM_W-1:0];
            res.beat.best_row = best_r;
            res.beat.best_col = best_c;
            res.beat.top_left = kept_tl;
            res.beat.top_right = kept_tr;
            res.beat.bottom_left = kept_bl;
            res.beat.bottom_right = kept_br;
            best_window_queue.push_back(res);
            left_elem = '0;
            upper_left_elem = '0;
            row_pos = 0;
            col_pos = 0;
            best_total = 0;
            best_r = '0;
            best_c = '0;
            kept_found = 1'b0;
            kept_tl = '0;
            kept_tr = '0;
            kept_bl = '0;
            kept_br = '0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] expected,
                                        input logic [63:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %0h, actual %0h", name, expected, actual);
            failures++;
        end
    endfunction

    function automatic data_kind_e pick_kind();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 8)
            return DATA_FULL;
        if (roll < 14)
            return DATA_SMALL;
        if (roll < 17)
            return DATA_EXTREME;
        return DATA_NEGATIVE;
    endfunction

    function automatic logic [ELEM_W-1:0] random_element(input data_kind_e kind);
        case (kind)
            DATA_SMALL:
                return ELEM_W'($urandom_range(0, 4)) - ELEM_W'(2);
            DATA_EXTREME:
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h0000_0000;
                    default: return 32'h0000_0001;
                endcase
            DATA_NEGATIVE:
                return {1'b1, 31'($urandom())};
            default:
                return $urandom();
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_size();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return CFG_W'($urandom_range(0, 1));
        if (roll == 1)
            return CFG_W'($urandom_range(7, 40));
        return CFG_W'($urandom_range(2, 6));
    endfunction

    // model update and result check on each beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (best_window_queue.size() == 0)
                begin
                    $error("result beat with no matrix pending");
                    failures++;
                end
                else
                begin
                    want_window = best_window_queue.pop_front();
                    seen_beat = result_beat_t'(m_axis_tdata);
                    check_field("found", want_window.found, m_axis_tuser[0]);
                    check_field("best_sum", want_window.beat.best_sum, seen_beat.best_sum);
                    check_field("best_row", want_window.beat.best_row, seen_beat.best_row);
                    check_field("best_col", want_window.beat.best_col, seen_beat.best_col);
                    check_field("top_left", want_window.beat.top_left, seen_beat.top_left);
                    check_field("top_right", want_window.beat.top_right,
                                seen_beat.top_right);
                    check_field("bottom_left", want_window.beat.bottom_left,
                                seen_beat.bottom_left);
                    check_field("bottom_right", want_window.beat.bottom_right,
                                seen_beat.bottom_right);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_window_search(s_axis_tdata);
        end
    end

    // output stall pattern, with long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (ready_phase == 0)
            begin
                ready_phase = $urandom_range(4, 40);
                ready_mode = $urandom_range(0, 3);
            end
            ready_phase--;
            case (ready_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= $urandom_range(0, 1) == 0;
                2:       m_axis_tready <= $urandom_range(0, 3) == 0;
                default: m_axis_tready <= $urandom_range(0, 4) != 0;
            endcase
        end
    end

    initial
    begin
        while (idle_cycles < ACCEPT_TIMEOUT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready) || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic write_register(input cfg_reg_e index, input logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] wdata;
        wdata = $urandom();
        wdata[CFG_W-1:0] = value;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == REG_NUM_ROWS)
            size_rows = value;
        else
            size_cols = value;
    endtask

    task automatic send_element(input logic [ELEM_W-1:0] elem);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 9) < 6)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12))
                    @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= elem;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_matrix(input data_kind_e kind);
        repeat (fit_size(size_rows, DEF_MAX_ROWS) * fit_size(size_cols, DEF_MAX_COLS))
            send_element(random_element(kind));
    endtask

    // stop sending and let every pending result come out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (best_window_queue.size() != 0)
            @(posedge clk);
        repeat (6)
            @(posedge clk);
    endtask

    task automatic test_directed_windows();
        write_register(REG_NUM_ROWS, CFG_W'(2));
        write_register(REG_NUM_COLS, CFG_W'(2));
        // largest possible sum
        repeat (4)
            send_element(32'h7FFF_FFFF);
        // all most negative, nothing found
        repeat (4)
            send_element(32'h8000_0000);
        // zero sum is not above zero
        repeat (4)
            send_element(32'h0000_0000);
        send_element(32'h0000_0001);
        send_element(32'h0000_0000);
        send_element(32'hFFFF_FFFF);
        send_element(32'h0000_0001);
        wait_idle();
        // equal sums everywhere, first window kept
        write_register(REG_NUM_ROWS, CFG_W'(3));
        write_register(REG_NUM_COLS, CFG_W'(3));
        repeat (9)
            send_element(32'h0000_0001);
        wait_idle();
    endtask

    task automatic test_size_limits();
        write_register(REG_NUM_ROWS, CFG_W'(0));
        write_register(REG_NUM_COLS, CFG_W'(1));
        send_matrix(pick_kind());
        wait_idle();
        write_register(REG_NUM_ROWS, CFG_W'(40));
        write_register(REG_NUM_COLS, CFG_W'(0));
        send_matrix(DATA_FULL);
        wait_idle();
        write_register(REG_NUM_ROWS, CFG_W'(1));
        write_register(REG_NUM_COLS, CFG_W'(40));
        send_matrix(DATA_FULL);
        wait_idle();
    endtask

    task automatic test_output_stall();
        write_register(REG_NUM_ROWS, CFG_W'(2));
        write_register(REG_NUM_COLS, CFG_W'(2));
        hold_requests++;
        repeat (40)
            send_matrix(pick_kind());
        wait_idle();
    endtask

    task automatic test_random_matrices();
        int unsigned start_count;
        int unsigned matrices;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            write_register(REG_NUM_ROWS, random_size());
            write_register(REG_NUM_COLS, random_size());
            matrices = $urandom_range(2, 8);
            while (matrices != 0 && items_sent - start_count < RANDOM_ITEMS)
            begin
                send_matrix(pick_kind());
                matrices--;
            end
            wait_idle();
        end
    endtask

    initial
    begin
        foreach (line_buf[i])
            line_buf[i] = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        test_directed_windows();
        test_size_limits();
        test_output_stall();
        test_random_matrices();
        wait_idle();
        if (failures == 0 && best_window_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
